// ===== sv/nsrc_pkg.sv =====
// Shared types, constants and sample conversion for the nearest-neighbour rate converter.
package nsrc_pkg;

  localparam int unsigned STEP_W      = 16;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned OUT_COUNT_W = 24;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned INDEX_W     = 24;
  localparam int unsigned CFG_ADDR_W  = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned MAX_OUT     = 8;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned POS_EXTRA_W = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [STEP_W-1:0] STEP_RESET  = 16'd256;
  localparam logic [MODE_W-1:0] MODE_BYTE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORD   = 2'd2;
  localparam logic [7:0]        BYTE_OFFSET = 8'h80;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_STEP      = 2'd0,
    REG_IN_WIDTH  = 2'd1,
    REG_OUT_WIDTH = 2'd2,
    REG_OUT_COUNT = 2'd3
  } nsrc_reg_e;

  // Per-cycle control from the sequencer to the top level
  typedef struct packed {
    logic fire;   // one result goes to the output register this cycle
    logic done;   // held item finishes this cycle
    logic last;   // result being emitted is the final one of the sound
  } nsrc_seq_st_t;

  // Map a raw input word to the output sample format
  function automatic logic [SAMPLE_W-1:0] convert_sample(
    input logic [SAMPLE_W-1:0] raw,
    input logic [MODE_W-1:0]   in_width,
    input logic [MODE_W-1:0]   out_width
  );
    logic [SAMPLE_W-1:0] s16;
    if (in_width == MODE_WORD) begin
      s16 = raw;
    end else begin
      s16 = {raw[7:0] ^ BYTE_OFFSET, 8'h00};
    end
    if (out_width == MODE_WORD) begin
      return s16;
    end
    return {{8{s16[15]}}, s16[15:8]};
  endfunction

endpackage

// ===== sv/nsrc_seq.sv =====
// Emission sequencer: counters, (COUNT_BITS+8).8 position and per-item output stepping.
module nsrc_seq #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                start_i,
  input  logic                                space_i,
  input  logic [nsrc_pkg::STEP_W-1:0]         step_i,
  input  logic [nsrc_pkg::OUT_COUNT_W-1:0]    out_count_i,
  output logic                                busy_o,
  output nsrc_pkg::nsrc_seq_st_t              status_o,
  output logic [nsrc_pkg::INDEX_W-1:0]        index_o
);
  import nsrc_pkg::*;

  localparam int unsigned PW = COUNT_BITS + POS_EXTRA_W;
  localparam int unsigned CW = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam int unsigned NW = $clog2(MAX_OUT + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [NW-1:0] N_LAST = NW'(MAX_OUT - 1);
  localparam logic [NW-1:0] N_MAX  = NW'(MAX_OUT);

  logic                  busy_q, busy_d;
  logic [NW-1:0]         n_q, n_d;
  logic [COUNT_BITS-1:0] ic_q, ic_d;
  logic [COUNT_BITS-1:0] oc_q, oc_d;
  logic [PW-1:0]         pos_q, pos_d;

  logic [PW-1:0]         pos_next;
  logic [COUNT_BITS-1:0] oc_next;
  logic [PW-FRAC_W-1:0]  ic_ext;
  logic [CW-1:0]         cnt_ext;
  logic                  can_emit, can_next, fire, done;

  assign pos_next = pos_q + PW'(step_i);
  assign oc_next  = oc_q + COUNT_BITS'(1);
  assign ic_ext   = (PW-FRAC_W)'(ic_q);
  assign cnt_ext  = CW'(out_count_i);

  assign can_emit = busy_q && (n_q != N_MAX) && (CW'(oc_q) < cnt_ext) &&
                    (oc_q != COUNT_MAX) && (pos_q[PW-1:FRAC_W] <= ic_ext);
  // look one result ahead so a single-result item frees the input in the cycle it emits its result
  assign can_next = (n_q != N_LAST) && (CW'(oc_next) < cnt_ext) &&
                    (oc_next != COUNT_MAX) && (pos_next[PW-1:FRAC_W] <= ic_ext);
  assign fire     = can_emit && space_i;
  assign done     = busy_q && (!can_emit || (fire && !can_next));

  always_comb begin
    busy_d = busy_q;
    n_d    = n_q;
    ic_d   = ic_q;
    oc_d   = oc_q;
    pos_d  = pos_q;
    if (fire) begin
      pos_d = pos_next;
      oc_d  = oc_next;
      n_d   = n_q + NW'(1);
    end
    if (done) begin
      busy_d = 1'b0;
      if (ic_q != COUNT_MAX) begin
        ic_d = ic_q + COUNT_BITS'(1);
      end
    end
    if (accept_i) begin
      busy_d = 1'b1;
      n_d    = '0;
      if (start_i) begin
        ic_d  = '0;
        oc_d  = '0;
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      n_q    <= '0;
      ic_q   <= '0;
      oc_q   <= '0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      n_q    <= n_d;
      ic_q   <= ic_d;
      oc_q   <= oc_d;
      pos_q  <= pos_d;
    end
  end

  assign busy_o        = busy_q;
  assign status_o.fire = fire;
  assign status_o.done = done;
  assign status_o.last = (CW'(oc_next) == cnt_ext);
  assign index_o       = INDEX_W'(oc_q);

endmodule

// ===== sv/nearest_sample_rate_converter.sv =====
// Top level of the nearest-neighbour sample rate converter.
//
// Input samples arrive on the s_axis channel (tdata: raw sample, tuser: start
// of a new sound). Each item yields zero to eight resampled items on the
// m_axis channel, output number i taking input floor(i * step / 256) or, when
// the cap of eight holds it back, a later one, with tlast marking output number
// out_count - 1. Configuration is a plain write port (step, in_width, out_width,
// out_count); the user must write it while idle; the block does not enforce it.
// The first result of an item is loaded into the output register once the
// sequencer holds the item and the output register has space. An item that
// yields zero or one result frees the input side as it finishes, so such items
// stream at one per cycle while the receiver keeps up; one yielding several holds
// the input until its last result is loaded, at one result per unstalled cycle.
//
// Reset clears the counters and the position and loads the register defaults
// (step 256, 8-bit in and out, no outputs). When the receiver stalls, the
// output register holds its result and the sequencer waits; the input side
// drops ready until the held item has passed its last result to the output
// register, while an item that yields nothing still frees the input at once.
module nearest_sample_rate_converter #(
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [nsrc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [nsrc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input samples
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [nsrc_pkg::SAMPLE_W-1:0]        s_axis_tdata_i,  // [15:0] raw_sample
  input  logic                                 s_axis_tuser_i,  // [0] start_req
  // resampled output
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  output logic [nsrc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,  // [15:0] sample_out,
                                                                // [39:16] out_index
  output logic                                 m_axis_tlast_o
);
  import nsrc_pkg::*;

  // configuration registers
  logic [STEP_W-1:0]      step_q;
  logic [MODE_W-1:0]      in_width_q;
  logic [MODE_W-1:0]      out_width_q;
  logic [OUT_COUNT_W-1:0] out_count_q;

  // held input sample and output register
  logic [SAMPLE_W-1:0]    sample_q;
  logic                   out_valid_q;
  logic [SAMPLE_W-1:0]    out_sample_q;
  logic [INDEX_W-1:0]     out_index_q;
  logic                   out_last_q;

  logic                   in_accept;
  logic                   out_space;
  logic                   seq_busy;
  nsrc_seq_st_t           seq_st;
  logic [INDEX_W-1:0]     seq_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      in_width_q  <= MODE_BYTE;
      out_width_q <= MODE_BYTE;
      out_count_q <= '0;
    end else if (cfg_we_i) begin
      case (nsrc_reg_e'(cfg_addr_i))
        REG_STEP:      step_q      <= cfg_wdata_i[STEP_W-1:0];
        REG_IN_WIDTH:  in_width_q  <= cfg_wdata_i[MODE_W-1:0];
        REG_OUT_WIDTH: out_width_q <= cfg_wdata_i[MODE_W-1:0];
        REG_OUT_COUNT: out_count_q <= cfg_wdata_i[OUT_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // take a new item when nothing is held or the held one finishes now
  assign s_axis_tready_o = !seq_busy || seq_st.done;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign out_space       = !out_valid_q || m_axis_tready_i;

  // convert on entry; the format registers must stay unchanged while busy, a rule the block leaves to the user
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= convert_sample(s_axis_tdata_i, in_width_q, out_width_q);
    end
  end

  nsrc_seq #(
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .start_i     (s_axis_tuser_i),
    .space_i     (out_space),
    .step_i      (step_q),
    .out_count_i (out_count_q),
    .busy_o      (seq_busy),
    .status_o    (seq_st),
    .index_o     (seq_index)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_st.fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // hold the payload while stalled, load on each emitted result
  always_ff @(posedge clk_i) begin
    if (seq_st.fire) begin
      out_sample_q <= sample_q;
      out_index_q  <= seq_index;
      out_last_q   <= seq_st.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_index_q, out_sample_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== sv/nsrc_chk.sv =====
// Port-level checker for the rate converter, bound to the top level.
module nsrc_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 cfg_we_i,
  input logic [nsrc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input logic [nsrc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input logic                                 m_axis_tvalid_o,
  input logic                                 m_axis_tready_i,
  input logic [nsrc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input logic                                 m_axis_tlast_o
);
  import nsrc_pkg::*;

  logic [OUT_COUNT_W-1:0] cnt_q;
  logic [INDEX_W-1:0]     index;

  // shadow the output count as written through the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i && (nsrc_reg_e'(cfg_addr_i) == REG_OUT_COUNT)) begin
      cnt_q <= cfg_wdata_i[OUT_COUNT_W-1:0];
    end
  end

  assign index = m_axis_tdata_o[OUT_TDATA_W-1:SAMPLE_W];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (OUT_COUNT_W'(index) < cnt_q))
    else $error("result index at or beyond the output count");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tlast_o == ((OUT_COUNT_W + 1)'(index) + (OUT_COUNT_W + 1)'(1) ==
                          (OUT_COUNT_W + 1)'(cnt_q))))
    else $error("tlast disagrees with the result index");

endmodule

bind nearest_sample_rate_converter nsrc_chk u_nsrc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_we_i        (cfg_we_i),
  .cfg_addr_i      (cfg_addr_i),
  .cfg_wdata_i     (cfg_wdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the nearest-neighbour sample rate converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nsrc_pkg::*;

  // Cycles with no item moving on either side before the run is abandoned
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 16;

  // One resampled item as the block should emit it
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [INDEX_W-1:0]  index;
    logic                last;
  } resampled_t;

  // Own copy of the converter state; works out the items each input sample yields
  class resample_scoreboard;
    resampled_t           expected_q[$];
    logic [STEP_W-1:0]    step_r    = STEP_RESET;
    logic [MODE_W-1:0]    in_w      = MODE_BYTE;
    logic [MODE_W-1:0]    out_w     = MODE_BYTE;
    logic [INDEX_W-1:0]   out_total = '0;
    logic [INDEX_W-1:0]   in_cnt    = '0;
    logic [INDEX_W-1:0]   out_cnt   = '0;
    logic [INDEX_W+15:0]  pos       = '0;
    int unsigned          errors    = 0;

    function void set_reg(nsrc_reg_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_STEP:      step_r    = v[STEP_W-1:0];
        REG_IN_WIDTH:  in_w      = v[MODE_W-1:0];
        REG_OUT_WIDTH: out_w     = v[MODE_W-1:0];
        REG_OUT_COUNT: out_total = v[INDEX_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] raw, logic start);
      logic [SAMPLE_W-1:0] wide;
      logic [SAMPLE_W-1:0] smp;
      int unsigned         emitted;
      resampled_t          r;
      // a start request clears the counters before this sample is used
      if (start) begin
        in_cnt  = '0;
        out_cnt = '0;
        pos     = '0;
      end
      // byte input is offset binary in the low byte; anything but word mode is byte mode
      if (in_w == MODE_WORD) begin
        wide = raw;
      end else begin
        wide = {raw[7:0] ^ BYTE_OFFSET, 8'h00};
      end
      if (out_w == MODE_WORD) begin
        smp = wide;
      end else begin
        smp = {{8{wide[15]}}, wide[15:8]};
      end
      // emit while the next output position falls on or before this input
      emitted = 0;
      while (emitted < MAX_OUT && out_cnt < out_total && out_cnt != '1
             && (pos >> FRAC_W) <= (INDEX_W+16)'(in_cnt)) begin
        r.sample = smp;
        r.index  = out_cnt;
        r.last   = (out_cnt + INDEX_W'(1) == out_total);
        expected_q.push_back(r);
        pos     = pos + (INDEX_W+16)'(step_r);
        out_cnt = out_cnt + INDEX_W'(1);
        emitted++;
      end
      if (in_cnt != '1) begin
        in_cnt = in_cnt + INDEX_W'(1);
      end
    endfunction

    function void check_output(logic [OUT_TDATA_W-1:0] data, logic tlast);
      resampled_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected item: sample %h index %0d last %b",
                   data[15:0], data[39:16], tlast);
        end
        return;
      end
      want = expected_q.pop_front();
      if (data[15:0] !== want.sample || data[39:16] !== want.index || tlast !== want.last) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("item mismatch: expected sample %h index %0d last %b, got %h %0d %b",
                   want.sample, want.index, want.last, data[15:0], data[39:16], tlast);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // count every item still owed at the end as a failure
    function void flush_leftovers();
      if (expected_q.size() != 0) begin
        if (errors < REPORT_MAX) begin
          $display("%0d expected items never arrived, first index %0d",
                   expected_q.size(), expected_q[0].index);
        end
        errors += expected_q.size();
        expected_q.delete();
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  nsrc_reg_e              cfg_addr  = REG_STEP;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [SAMPLE_W-1:0]    s_tdata   = '0;  // [15:0] raw_sample
  logic                   s_tuser   = 1'b0; // [0] start_req
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [15:0] sample_out, [39:16] out_index
  logic                   m_tlast;

  resample_scoreboard sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  nearest_sample_rate_converter #(
    .COUNT_BITS(24)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4ns;
    clk_i = 1'b1;
    #4ns;
  end

  // Receiver: check what was accepted at this edge, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_n && m_tvalid && m_tready) begin
      sb.check_output(m_tdata, m_tlast);
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: give up once nothing has moved for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one input item, idling first at the current rate, and hold it until taken
  task automatic send_sample(logic [SAMPLE_W-1:0] raw, logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    s_tuser  <= start;
    do @(posedge clk_i); while (!s_tready);
    sb.note_sample(raw, start);
  endtask

  // Drop valid and wait for every owed item; the block may still be busy on
  // an item that yields nothing, so also wait out settle_cycles
  task automatic drain(int unsigned settle_cycles);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (settle_cycles) @(posedge clk_i);
  endtask

  task automatic write_reg(nsrc_reg_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  // Write the whole register set; call only with the block idle
  task automatic configure(logic [STEP_W-1:0] step, logic [MODE_W-1:0] in_mode,
                           logic [MODE_W-1:0] out_mode, logic [INDEX_W-1:0] count);
    write_reg(REG_STEP, CFG_DATA_W'(step));
    write_reg(REG_IN_WIDTH, CFG_DATA_W'(in_mode));
    write_reg(REG_OUT_WIDTH, CFG_DATA_W'(out_mode));
    write_reg(REG_OUT_COUNT, CFG_DATA_W'(count));
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [STEP_W-1:0]  step;
    logic [INDEX_W-1:0] count;
    int unsigned        mode;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: no outputs at all while out_count is zero
    send_sample(16'h00FF, 1'b1);
    send_sample(16'h1234, 1'b0);
    drain(8);

    // Word in, word out, one for one: extremes of the signed range
    configure(16'd256, MODE_WORD, MODE_WORD, 24'd6);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    drain(8);

    // Mode codes 0 and 3 count as byte mode; byte extremes, the last flag,
    // then a sample after the sound has finished
    configure(16'd256, 2'd0, 2'd3, 24'd5);
    send_sample(16'hFF00, 1'b1);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h0080, 1'b0);
    send_sample(16'h007F, 1'b0);
    send_sample(16'hAA55, 1'b0);
    send_sample(16'h1111, 1'b0);
    drain(8);

    // Zero step: eight per input until the count runs out
    configure(16'd0, MODE_WORD, MODE_BYTE, 24'd12);
    send_sample(16'h1234, 1'b1);
    send_sample(16'h5678, 1'b0);
    send_sample(16'h9ABC, 1'b0);
    drain(8);

    // Step below the cap: outputs lag behind the input and take the current sample
    configure(16'd1, 2'd3, MODE_WORD, 24'd20);
    send_sample(16'h4321, 1'b1);
    send_sample(16'h8765, 1'b0);
    send_sample(16'hCBA9, 1'b0);
    drain(8);

    // Smallest step without lag; restart in the middle of a sound
    configure(16'd32, MODE_WORD, 2'd0, 24'd40);
    send_sample(16'h0F0F, 1'b1);
    send_sample(16'hF0F0, 1'b0);
    send_sample(16'h3C3C, 1'b1);
    drain(8);

    // Largest step and largest count
    configure(16'hFFFF, MODE_WORD, MODE_WORD, 24'hFFFFFF);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8001, 1'b0);
    drain(8);

    // Random sounds, one setting and one idling pattern per phase
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: step = STEP_W'($urandom_range(512, 128));
        1: step = STEP_W'($urandom_range(31));
        2: step = STEP_W'($urandom_range(96, 32));
        3: step = STEP_W'($urandom());
        4: step = 16'd256;
        5: step = 16'hFFFF;
        6: step = STEP_W'($urandom_range(400, 200));
        default: step = STEP_W'($urandom_range(1, 31));
      endcase
      if (p == 4) begin
        count = 24'hFFFFFF;
      end else begin
        count = INDEX_W'($urandom_range(60, (p == 6) ? 0 : 1));
      end
      configure(step, MODE_W'($urandom_range(3)), MODE_W'($urandom_range(3)), count);

      // cycle through: no idling, sender idle, receiver stalls, both
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 69 : (mode == 3) ? 35 : 0;
      recv_stall_pct = (mode == 2) ? 69 : (mode == 3) ? 35 : 0;

      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // hold off once until the receiver has taken everything owed
        if (p == 2 && k == PHASE_ITEMS / 2) begin
          s_tvalid <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
        send_sample(SAMPLE_W'($urandom()),
                    (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
      end
      drain(8);
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain(16);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
